// ===== src/assert_macros.svh =====
// Assertion macros shared by the SPI slave watchdog modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SPISW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition at one edge implies a property at the next edge.
`define SPISW_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== src/spisw_pkg.sv =====
// Package with the types and constants of the SPI slave watchdog.
package spisw_pkg;

  localparam int WATCHDOG_WIDTH = 20;
  localparam int LIMIT_W        = 20;
  localparam int CMP_W          = (WATCHDOG_WIDTH > LIMIT_W) ? WATCHDOG_WIDTH : LIMIT_W;
  localparam int BITS_PER_BYTE  = 8;
  localparam int BIT_POS_W      = $clog2(BITS_PER_BYTE);
  localparam int CFG_DATA_W     = LIMIT_W;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = LIMIT_W'(100000);
  localparam logic [WATCHDOG_WIDTH-1:0] WD_MAX = '1;

  localparam int ERR_RX_BIT = 0;
  localparam int ERR_TX_BIT = 1;

  localparam logic DIR_RX = 1'b0;
  localparam logic DIR_TX = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IDLE_LEVEL = 2'd0,
    REG_DIRECTION  = 2'd1,
    REG_TIMEOUT    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               idle_level;
    logic               direction;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic       miso;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] byte_position;
    logic [1:0] error_flags;
    logic       aborted;
  } result_t;

endpackage

// ===== src/spisw_cfg.sv =====
// Configuration registers of the SPI slave watchdog.
module spisw_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [spisw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [spisw_pkg::CFG_DATA_W-1:0]     cfg_data,
  output spisw_pkg::cfg_t                      cfg
);

  spisw_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_level <= 1'b0;
      cfg_r.direction  <= spisw_pkg::DIR_RX;
      cfg_r.limit      <= spisw_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        spisw_pkg::REG_IDLE_LEVEL: cfg_r.idle_level <= cfg_data[0];
        spisw_pkg::REG_DIRECTION:  cfg_r.direction  <= cfg_data[0];
        spisw_pkg::REG_TIMEOUT:    cfg_r.limit      <= cfg_data[spisw_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/spisw_core.sv =====
// Transfer state, edge detection, shifting and watchdog of the SPI slave.
`include "assert_macros.svh"

module spisw_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 cs_n,
  input  logic                 sck,
  input  logic                 mosi,
  input  logic [7:0]           tx_byte,
  input  spisw_pkg::cfg_t      cfg,
  output spisw_pkg::result_t   res
);

  logic                                    armed_r, armed_nxt;
  logic [spisw_pkg::BIT_POS_W-1:0]         bit_r, bit_nxt;
  logic [7:0]                              pos_r, pos_nxt;
  logic [7:0]                              acc_r, acc_nxt, acc_shift;
  logic [spisw_pkg::WATCHDOG_WIDTH-1:0]    cnt_r, cnt_nxt, cnt_base;
  logic [1:0]                              err_r, err_nxt;
  logic                                    abort_r, abort_nxt;
  logic                                    miso_r, miso_nxt;
  logic                                    fire;
  logic [7:0]                              rx_out;
  logic                                    rx_vld;

  always_comb begin
    armed_nxt = armed_r;
    bit_nxt   = bit_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    abort_nxt = abort_r;
    miso_nxt  = miso_r;
    rx_out    = 8'd0;
    rx_vld    = 1'b0;
    fire      = 1'b0;
    cnt_base  = cnt_r;
    acc_shift = acc_r | (8'(mosi) << bit_r);
    if (cs_n) begin
      bit_nxt   = '0;
      pos_nxt   = 8'd0;
      acc_nxt   = 8'd0;
      cnt_nxt   = '0;
      abort_nxt = 1'b0;
      miso_nxt  = cfg.direction;
    end else if (!abort_r) begin
      if (cfg.direction == spisw_pkg::DIR_RX) begin
        miso_nxt = 1'b0;
      end
      fire = armed_r && (sck != cfg.idle_level);
      if (fire) begin
        if (cfg.direction == spisw_pkg::DIR_TX) begin
          miso_nxt = tx_byte[bit_r];
        end else begin
          acc_nxt = acc_shift;
        end
        if (bit_r == spisw_pkg::BIT_POS_W'(spisw_pkg::BITS_PER_BYTE - 1)) begin
          bit_nxt = '0;
          pos_nxt = pos_r + 8'd1;
          if (cfg.direction == spisw_pkg::DIR_RX) begin
            rx_out  = acc_shift;
            rx_vld  = 1'b1;
            acc_nxt = 8'd0;
          end
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
        armed_nxt = 1'b0;
        cnt_base  = '0;
      end
      if (sck == cfg.idle_level) begin
        armed_nxt = 1'b1;
      end
      cnt_nxt = cnt_base;
      if (spisw_pkg::CMP_W'(cnt_base) >= spisw_pkg::CMP_W'(cfg.limit)) begin
        abort_nxt = 1'b1;
        if (cfg.direction == spisw_pkg::DIR_TX) begin
          err_nxt[spisw_pkg::ERR_TX_BIT] = 1'b1;
        end else begin
          err_nxt[spisw_pkg::ERR_RX_BIT] = 1'b1;
        end
      end else if (cnt_base != spisw_pkg::WD_MAX) begin
        cnt_nxt = cnt_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b1;
      bit_r   <= '0;
      pos_r   <= 8'd0;
      acc_r   <= 8'd0;
      cnt_r   <= '0;
      err_r   <= 2'd0;
      abort_r <= 1'b0;
      miso_r  <= 1'b0;
    end else if (accept) begin
      armed_r <= armed_nxt;
      bit_r   <= bit_nxt;
      pos_r   <= pos_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      abort_r <= abort_nxt;
      miso_r  <= miso_nxt;
    end
  end

  always_comb begin
    res.miso          = miso_nxt;
    res.rx_byte       = rx_out;
    res.rx_valid      = rx_vld;
    res.byte_position = pos_nxt;
    res.error_flags   = err_nxt;
    res.aborted       = abort_nxt;
  end

  `SPISW_ASSERT(a_abort_has_error, !abort_r || (err_r != 2'd0), "abort without an error flag")
  `SPISW_ASSERT(a_rx_only_receive, !rx_vld || !fire || (cfg.direction == spisw_pkg::DIR_RX), "byte completed in transmit mode")
  `SPISW_ASSERT_NEXT(a_deselect_clears, accept && cs_n, (pos_r == 8'd0) && (bit_r == '0) && !abort_r, "deselect did not clear the transfer")
  `SPISW_ASSERT_NEXT(a_abort_holds, accept && !cs_n && abort_r, abort_r && $stable(pos_r) && $stable(cnt_r), "aborted transfer changed state")

endmodule

// ===== src/spi_slave_lsb_first_watchdog.sv =====
// Top level of the LSB-first SPI slave with clock watchdog.
// One item is one sample of cs_n, sck and mosi plus the byte to transmit, and each
// item yields exactly one result: the MISO level, a received byte with its flag,
// the byte position, the sticky timeout flags and the abort status. The state is
// updated and the result is registered in the cycle the item is accepted, so a new
// item is taken every cycle as long as the result register is empty or being emptied
// at the same edge. The watchdog aborts the transfer once the count of samples
// without a clock edge reaches the timeout register's limit; the abort lasts until
// cs_n goes high again.
`include "assert_macros.svh"

module spi_slave_lsb_first_watchdog (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [spisw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [spisw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cs_n,
  input  logic                                 in_sck,
  input  logic                                 in_mosi,
  input  logic [7:0]                           in_tx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_miso,
  output logic [7:0]                           out_rx_byte,
  output logic                                 out_rx_valid,
  output logic [7:0]                           out_byte_position,
  output logic [1:0]                           out_error_flags,
  output logic                                 out_aborted
);

  spisw_pkg::cfg_t    cfg;
  spisw_pkg::result_t res;
  spisw_pkg::result_t res_r;
  logic               out_valid_r;
  logic               accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  spisw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spisw_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cs_n    (in_cs_n),
    .sck     (in_sck),
    .mosi    (in_mosi),
    .tx_byte (in_tx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_miso          = res_r.miso;
  assign out_rx_byte       = res_r.rx_byte;
  assign out_rx_valid      = res_r.rx_valid;
  assign out_byte_position = res_r.byte_position;
  assign out_error_flags   = res_r.error_flags;
  assign out_aborted       = res_r.aborted;

  `SPISW_ASSERT_NEXT(a_accept_fills, accept, out_valid_r, "accepted item left no result")
  `SPISW_ASSERT_NEXT(a_rx_byte_zero, accept && !res.rx_valid, res_r.rx_byte == 8'd0, "idle received byte not zero")

endmodule
